/* hdl/va_pkg.sv */
// Package for the 3D vector angle block: widths, pipeline structs and the
// arctangent table used by the CORDIC cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package va_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_W         = ANGLE_FRAC_BITS + 2;

    localparam int PROD_W       = 2 * COMPONENT_WIDTH;
    localparam int MAG_W        = 2 * COMPONENT_WIDTH;
    localparam int LEN_W        = $clog2(MAG_W + 1);
    localparam int NORM_W       = 31;
    localparam int DP_W         = 64;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_ITERS = 40;
    localparam int TAB_FRAC     = 60;
    localparam int LEG_SCALE    = 24;
    localparam int ROUND_SHIFT  = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int SHIFT_W      = 6;

    typedef struct packed {
        logic vld;
        logic degen;
        logic dneg;
    } va_tag_t;

    typedef struct packed {
        logic [DP_W-1:0]   rem;
        logic [DP_W-1:0]   root;
        logic [NORM_W-1:0] dmag;
    } sqrt_data_t;

    typedef struct packed {
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [DP_W-1:0] z;
    } cordic_data_t;

    typedef logic [CORDIC_ITERS-1:0][DP_W-1:0] atan_tab_t;

    // Restoring long division, evaluated at elaboration only.
    function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in Q60 from its alternating series, truncating each term.
    function automatic logic [63:0] atan_recip(input logic [63:0] n);
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] k;
        logic        done;
        t    = cdiv(64'd1 << TAB_FRAC, n);
        s    = t;
        k    = 64'd1;
        done = 1'b0;
        for (int j = 0; j < 64; j++) begin
            if (!done) begin
                t = cdiv(cdiv(t, n), n);
                if (t == 64'd0) begin
                    done = 1'b1;
                end
                else begin
                    if (k[0]) s = s - cdiv(t, 64'd2 * k + 64'd1);
                    else      s = s + cdiv(t, 64'd2 * k + 64'd1);
                    k = k + 64'd1;
                end
            end
        end
        return s;
    endfunction

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t tab;
        tab[0] = (atan_recip(64'd5) << 2) - atan_recip(64'd239);
        for (int i = 1; i < CORDIC_ITERS; i++) begin
            tab[i] = atan_recip(64'd1 << i);
        end
        return tab;
    endfunction

    localparam atan_tab_t   ATAN_TAB   = build_atan_tab();
    localparam logic [63:0] HALF_PI    = ATAN_TAB[0] << 1;
    localparam logic [63:0] PI_Q60     = ATAN_TAB[0] << 2;
    localparam logic [63:0] ROUND_HALF = 64'd1 << (ROUND_SHIFT - 1);
    localparam logic [63:0] PI_SUM     = PI_Q60 + ROUND_HALF;
    localparam logic [ANGLE_W-1:0] ANGLE_PI_Q = ANGLE_W'(PI_SUM >> ROUND_SHIFT);

endpackage

`default_nettype wire

/* hdl/va_front.sv */
// Front end: products, cross and dot terms, block normalisation, squares.
// Depends on va_pkg.
`timescale 1ns / 1ps
`default_nettype none

module va_front (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     en,
    input  wire logic                                     take,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] a_x,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] a_y,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] a_z,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] b_x,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] b_y,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] b_z,
    output va_pkg::va_tag_t                               tag,
    output va_pkg::sqrt_data_t                            data
);

    localparam int PW = va_pkg::PROD_W;
    localparam int MW = va_pkg::MAG_W;
    localparam int NW = va_pkg::NORM_W;
    localparam int LW = va_pkg::LEN_W;

    function automatic logic [LW-1:0] bit_len(input logic [MW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < MW; i++) begin
            if (v[i]) n = LW'(i + 1);
        end
        return n;
    endfunction

    function automatic logic [NW-1:0] norm(input logic [MW-1:0] v, input logic [LW-1:0] len);
        logic [63:0] ext;
        ext = 64'(v);
        if (len > LW'(NW)) return NW'(ext >> (len - LW'(NW)));
        else               return NW'(ext << (LW'(NW) - len));
    endfunction

    function automatic logic [MW-1:0] abs_diff(input logic signed [PW-1:0] p,
                                               input logic signed [PW-1:0] q);
        logic signed [PW:0] d;
        d = (PW+1)'(p) - (PW+1)'(q);
        if (d[PW]) d = -d;
        return MW'(d);
    endfunction

    // Stage 1: nine products.
    va_pkg::va_tag_t s1_tag_reg;
    logic signed [PW-1:0] p_reg [9];
    // Stage 2: cross magnitudes and dot magnitude.
    va_pkg::va_tag_t s2_tag_reg;
    logic [MW-1:0] c2_reg [3];
    logic [MW-1:0] d2_reg;
    // Stage 3: common bit length.
    va_pkg::va_tag_t s3_tag_reg;
    logic [MW-1:0] c3_reg [3];
    logic [MW-1:0] d3_reg;
    logic [LW-1:0] len_reg;
    // Stage 4: normalised legs.
    va_pkg::va_tag_t s4_tag_reg;
    logic [NW-1:0] c4_reg [3];
    logic [NW-1:0] d4_reg;
    // Stage 5: squares.
    va_pkg::va_tag_t s5_tag_reg;
    logic [2*NW-1:0] q5_reg [3];
    logic [NW-1:0] d5_reg;
    // Stage 6: sum of squares.
    va_pkg::va_tag_t s6_tag_reg;
    logic [va_pkg::DP_W-1:0] n6_reg;
    logic [NW-1:0] d6_reg;

    va_pkg::va_tag_t s1_tag_next;
    va_pkg::va_tag_t s2_tag_next;
    logic signed [PW+1:0] dot;
    logic [LW-1:0] len_next;

    always_comb
    begin
        s1_tag_next.vld   = take;
        s1_tag_next.degen = (a_x == '0 && a_y == '0 && a_z == '0) ||
                            (b_x == '0 && b_y == '0 && b_z == '0);
        s1_tag_next.dneg  = 1'b0;
        dot = (PW+2)'(p_reg[6]) + (PW+2)'(p_reg[7]) + (PW+2)'(p_reg[8]);
        s2_tag_next       = s1_tag_reg;
        s2_tag_next.dneg  = dot[PW+1];
        len_next = bit_len(c2_reg[0] | c2_reg[1] | c2_reg[2] | d2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
            s5_tag_reg <= '0;
            s6_tag_reg <= '0;
        end
        else if (en)
        begin
            s1_tag_reg <= s1_tag_next;
            s2_tag_reg <= s2_tag_next;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
            s5_tag_reg <= s4_tag_reg;
            s6_tag_reg <= s5_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= a_y * b_z;
            p_reg[1] <= a_z * b_y;
            p_reg[2] <= a_z * b_x;
            p_reg[3] <= a_x * b_z;
            p_reg[4] <= a_x * b_y;
            p_reg[5] <= a_y * b_x;
            p_reg[6] <= a_x * b_x;
            p_reg[7] <= a_y * b_y;
            p_reg[8] <= a_z * b_z;

            c2_reg[0] <= abs_diff(p_reg[0], p_reg[1]);
            c2_reg[1] <= abs_diff(p_reg[2], p_reg[3]);
            c2_reg[2] <= abs_diff(p_reg[4], p_reg[5]);
            d2_reg    <= dot[PW+1] ? MW'(-dot) : MW'(dot);

            c3_reg  <= c2_reg;
            d3_reg  <= d2_reg;
            len_reg <= len_next;

            for (int i = 0; i < 3; i++) begin
                c4_reg[i] <= norm(c3_reg[i], len_reg);
            end
            d4_reg <= norm(d3_reg, len_reg);

            for (int i = 0; i < 3; i++) begin
                q5_reg[i] <= (2*NW)'(c4_reg[i]) * (2*NW)'(c4_reg[i]);
            end
            d5_reg <= d4_reg;

            n6_reg <= 64'(q5_reg[0]) + 64'(q5_reg[1]) + 64'(q5_reg[2]);
            d6_reg <= d5_reg;
        end
    end

    assign tag       = s6_tag_reg;
    assign data.rem  = n6_reg;
    assign data.root = '0;
    assign data.dmag = d6_reg;

endmodule

`default_nettype wire

/* hdl/va_sqrt_cell.sv */
// One digit cell of the pipelined integer square root.
// Depends on va_pkg.
`timescale 1ns / 1ps
`default_nettype none

module va_sqrt_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic [va_pkg::SHIFT_W-1:0]    shift_pos,
    input  wire va_pkg::va_tag_t               tag_in,
    input  wire va_pkg::sqrt_data_t            data_in,
    output va_pkg::va_tag_t                    tag_out,
    output va_pkg::sqrt_data_t                 data_out
);

    va_pkg::va_tag_t    tag_reg;
    va_pkg::sqrt_data_t data_reg;
    va_pkg::sqrt_data_t data_next;
    logic [va_pkg::DP_W-1:0] bitv;
    logic [va_pkg::DP_W-1:0] trial;

    always_comb
    begin
        bitv      = 64'd1 << shift_pos;
        trial     = data_in.root + bitv;
        data_next = data_in;
        if (data_in.rem >= trial)
        begin
            data_next.rem  = data_in.rem - trial;
            data_next.root = (data_in.root >> 1) + bitv;
        end
        else
        begin
            data_next.root = data_in.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else if (en)
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign tag_out  = tag_reg;
    assign data_out = data_reg;

endmodule

`default_nettype wire

/* hdl/va_cordic_cell.sv */
// One vectoring iteration of the CORDIC arctangent chain.
// Depends on va_pkg.
`timescale 1ns / 1ps
`default_nettype none

module va_cordic_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic [va_pkg::SHIFT_W-1:0]    shift,
    input  wire logic [va_pkg::DP_W-1:0]       atan_step,
    input  wire va_pkg::va_tag_t               tag_in,
    input  wire va_pkg::cordic_data_t          data_in,
    output va_pkg::va_tag_t                    tag_out,
    output va_pkg::cordic_data_t               data_out
);

    va_pkg::va_tag_t      tag_reg;
    va_pkg::cordic_data_t data_reg;
    va_pkg::cordic_data_t data_next;
    logic signed [va_pkg::DP_W-1:0] xs;
    logic signed [va_pkg::DP_W-1:0] ys;

    always_comb
    begin
        xs = data_in.y >>> shift;
        ys = data_in.x >>> shift;
        if (!data_in.y[va_pkg::DP_W-1])
        begin
            data_next.x = data_in.x + xs;
            data_next.y = data_in.y - ys;
            data_next.z = data_in.z + $signed(atan_step);
        end
        else
        begin
            data_next.x = data_in.x - xs;
            data_next.y = data_in.y + ys;
            data_next.z = data_in.z - $signed(atan_step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else if (en)
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign tag_out  = tag_reg;
    assign data_out = data_reg;

endmodule

`default_nettype wire

/* hdl/va_back.sv */
// Back end: clamp and fold of the CORDIC angle, then rounding to the output format; degenerate pairs get a zero angle.
// Depends on va_pkg.
`timescale 1ns / 1ps
`default_nettype none

module va_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire va_pkg::va_tag_t                   tag_in,
    input  wire logic signed [va_pkg::DP_W-1:0]    z_in,
    output va_pkg::va_tag_t                        tag_out,
    output logic [va_pkg::ANGLE_W-1:0]             angle
);

    va_pkg::va_tag_t tag_a_reg;
    va_pkg::va_tag_t tag_b_reg;
    logic [va_pkg::DP_W-1:0]    z_a_reg;
    logic [va_pkg::ANGLE_W-1:0] angle_reg;
    logic [va_pkg::DP_W-1:0]    z_clamp;
    logic [va_pkg::DP_W-1:0]    z_a_next;
    logic [va_pkg::DP_W-1:0]    z_round;

    always_comb
    begin
        if (z_in[va_pkg::DP_W-1])
            z_clamp = '0;
        else if (z_in > $signed(va_pkg::HALF_PI))
            z_clamp = va_pkg::HALF_PI;
        else
            z_clamp = z_in;
        z_a_next = tag_in.dneg ? va_pkg::PI_Q60 - z_clamp : z_clamp;
        z_round  = (z_a_reg + va_pkg::ROUND_HALF) >> va_pkg::ROUND_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_a_reg   <= z_a_next;
            angle_reg <= tag_a_reg.degen ? '0 : va_pkg::ANGLE_W'(z_round);
        end
    end

    assign tag_out = tag_b_reg;
    assign angle   = angle_reg;

endmodule

`default_nettype wire

/* hdl/vector3_angle.sv */
// Top level of the 3D vector angle block: front end, square-root and CORDIC cell
// chains, back end and output skid stage. Depends on va_pkg and all va_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// -----
// Each transfer on the vec channel (vec_valid and vec_ready high at a clock edge)
// carries two vectors a and b of signed components. Each produces exactly one
// transfer on the res channel: angle_rad, the angle between the vectors in
// radians as unsigned Q2.13 (0 to pi), and degenerate, set when either vector is
// all zero, in which case the angle is 0.
// Throughput is one vector pair per cycle while vec_ready is high. The datapath
// is a chain of 80 register stages: six front-end stages, 32 square-root digit
// cells, 40 CORDIC iteration cells and two back-end stages; the output register
// adds one more. Every item follows the same path, so the latency does not
// depend on the data.
// When the receiver stalls, the result in the output register is held and the
// next one is parked in a skid register; only then does vec_ready fall and the
// whole chain freezes. vec_ready is driven from a register, so there is no
// combinational path from res_ready to vec_ready.
// Reset (rst_n low, asynchronous) empties the chain and both output registers;
// the block accepts items from the first cycle after reset is released.

module vector3_angle (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      vec_valid,
    output logic                                           vec_ready,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] a_x,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] a_y,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] a_z,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] b_x,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] b_y,
    input  wire logic signed [va_pkg::COMPONENT_WIDTH-1:0] b_z,
    output logic                                           res_valid,
    input  wire logic                                      res_ready,
    output logic [va_pkg::ANGLE_W-1:0]                     angle_rad,
    output logic                                           degenerate
);

    localparam int SQ = va_pkg::SQRT_STEPS;
    localparam int CI = va_pkg::CORDIC_ITERS;

    // The whole chain moves together unless a result is parked in the skid.
    logic en;
    logic take_in;

    va_pkg::va_tag_t      sq_tag  [SQ+1];
    va_pkg::sqrt_data_t   sq_data [SQ+1];
    va_pkg::va_tag_t      cd_tag  [CI+1];
    va_pkg::cordic_data_t cd_data [CI+1];
    va_pkg::va_tag_t      bk_tag;
    logic [va_pkg::ANGLE_W-1:0] bk_angle;

    // Output register with a skid register behind it.
    logic res_vld_reg;
    logic res_vld_next;
    logic skid_vld_reg;
    logic skid_vld_next;
    logic [va_pkg::ANGLE_W-1:0] angle_reg;
    logic                       degen_reg;
    logic [va_pkg::ANGLE_W-1:0] skid_angle_reg;
    logic                       skid_degen_reg;
    logic load_pipe;
    logic load_skid_out;
    logic load_skid;
    logic res_take;

    assign en      = !skid_vld_reg;
    assign take_in = vec_valid && vec_ready;

    va_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .take  (take_in),
        .a_x   (a_x),
        .a_y   (a_y),
        .a_z   (a_z),
        .b_x   (b_x),
        .b_y   (b_y),
        .b_z   (b_z),
        .tag   (sq_tag[0]),
        .data  (sq_data[0])
    );

    // Square-root digit cells: cell k decides the root bit whose square sits
    // at weight 2^(62-2k).
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        va_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift_pos (va_pkg::SHIFT_W'(62 - 2 * k)),
            .tag_in    (sq_tag[k]),
            .data_in   (sq_data[k]),
            .tag_out   (sq_tag[k+1]),
            .data_out  (sq_data[k+1])
        );
    end

    // Both legs of the triangle are scaled up before the rotations start.
    assign cd_tag[0]    = sq_tag[SQ];
    assign cd_data[0].x = $signed(64'(sq_data[SQ].dmag) << va_pkg::LEG_SCALE);
    assign cd_data[0].y = $signed(sq_data[SQ].root << va_pkg::LEG_SCALE);
    assign cd_data[0].z = '0;

    for (genvar i = 0; i < CI; i++) begin : g_cordic
        va_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift     (va_pkg::SHIFT_W'(i)),
            .atan_step (va_pkg::ATAN_TAB[i]),
            .tag_in    (cd_tag[i]),
            .data_in   (cd_data[i]),
            .tag_out   (cd_tag[i+1]),
            .data_out  (cd_data[i+1])
        );
    end

    va_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (cd_tag[CI]),
        .z_in    (cd_data[CI].z),
        .tag_out (bk_tag),
        .angle   (bk_angle)
    );

    always_comb
    begin
        res_take      = res_vld_reg && res_ready;
        res_vld_next  = res_vld_reg;
        skid_vld_next = skid_vld_reg;
        load_pipe     = 1'b0;
        load_skid_out = 1'b0;
        load_skid     = 1'b0;
        if (skid_vld_reg)
        begin
            if (res_take)
            begin
                load_skid_out = 1'b1;
                skid_vld_next = 1'b0;
            end
        end
        else if (bk_tag.vld)
        begin
            if (!res_vld_reg || res_take)
            begin
                load_pipe    = 1'b1;
                res_vld_next = 1'b1;
            end
            else
            begin
                load_skid     = 1'b1;
                skid_vld_next = 1'b1;
            end
        end
        else if (res_take)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg  <= res_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pipe)
        begin
            angle_reg <= bk_angle;
            degen_reg <= bk_tag.degen;
        end
        else if (load_skid_out)
        begin
            angle_reg <= skid_angle_reg;
            degen_reg <= skid_degen_reg;
        end
        if (load_skid)
        begin
            skid_angle_reg <= bk_angle;
            skid_degen_reg <= bk_tag.degen;
        end
    end

    assign vec_ready  = !skid_vld_reg;
    assign res_valid  = res_vld_reg;
    assign angle_rad  = angle_reg;
    assign degenerate = degen_reg;

    // A parked result always has a result in front of it.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> res_vld_reg)
        else $error("skid register full while output register empty");

    // A degenerate result always carries a zero angle.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && degen_reg) |-> (angle_reg == '0))
        else $error("degenerate result with nonzero angle");

    // The angle never exceeds pi in the output format.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> (angle_reg <= va_pkg::ANGLE_PI_Q))
        else $error("angle above pi");

    // A stalled result that is not taken stays in the output register, unchanged.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !res_ready) |=> (res_vld_reg && $stable(angle_reg)
                                         && $stable(degen_reg)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for vector3_angle: a directed table, then random vector
// pairs, each checked against the row's typed result or a bit-true angle predictor. Depends on va_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

    typedef logic signed [va_pkg::COMPONENT_WIDTH-1:0] comp_t;

    typedef struct {
        logic [va_pkg::ANGLE_W-1:0] angle;
        logic                       degen;
    } angle_res_t;

    // One row of the directed table. Where typed is set, the expected result is
    // written in the row itself rather than taken from the predictor.
    typedef struct {
        comp_t                      ax, ay, az, bx, by, bz;
        bit                         typed;
        logic [va_pkg::ANGLE_W-1:0] angle;
        logic                       degen;
    } vec_row_t;

    localparam int N_RANDOM      = 450;
    localparam int HOLD_AT       = 150;    // transfer count at which the long stall starts
    localparam int HOLD_CYCLES   = 400;    // well over the 81-stage chain
    localparam int CALM_FROM     = 250;    // no idling on either side in this window
    localparam int CALM_TO       = 350;
    localparam logic [va_pkg::ANGLE_W-1:0] HALF_PI_Q = 15'd12868;
    localparam logic [va_pkg::ANGLE_W-1:0] PI_Q      = 15'd25736;

    logic  clk;
    logic  rst_n;
    logic  vec_valid;
    logic  vec_ready;
    comp_t a_x, a_y, a_z, b_x, b_y, b_z;
    logic  res_valid;
    logic  res_ready;
    logic [va_pkg::ANGLE_W-1:0] angle_rad;
    logic  degenerate;

    angle_res_t      pending_angles[$];
    longint unsigned arctan_q60[va_pkg::CORDIC_ITERS];
    int              n_sent;
    int              n_checked;
    int              n_degen;
    int              n_errors;
    bit              sender_done;

    vector3_angle DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec_valid  (vec_valid),
        .vec_ready  (vec_ready),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .angle_rad  (angle_rad),
        .degenerate (degenerate)
    );

    always #10 clk = ~clk;

    // Arctangent of 1/n in Q60, summed from the alternating power series with
    // every term truncated, exactly as the hardware table is built.
    function automatic longint unsigned arctan_inv(input longint unsigned n);
        longint unsigned t;
        longint unsigned s;
        longint unsigned k;
        t = (64'd1 << 60) / n;
        s = t;
        k = 1;
        forever
        begin
            t = t / n / n;
            if (t == 0)
                break;
            if (k[0])
                s = s - t / (2 * k + 1);
            else
                s = s + t / (2 * k + 1);
            k++;
        end
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magnitude(input longint signed v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Angle between a and b: atan2(|a x b|, |a.b|) by CORDIC vectoring on a
    // block-normalised cross and dot product, folded when the dot product is negative.
    function automatic angle_res_t predict_angle(input comp_t ax, input comp_t ay,
                                                 input comp_t az, input comp_t bx,
                                                 input comp_t by, input comp_t bz);
        angle_res_t      r;
        longint unsigned cr[3];
        longint unsigned dmag;
        longint unsigned mx;
        longint unsigned leg;
        longint signed   dot;
        longint signed   x, y, z, xs, ys, half_pi, pi_full;
        int              len;
        bit              dneg;
        if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0))
        begin
            r.angle = '0;
            r.degen = 1'b1;
            return r;
        end
        cr[0] = magnitude(longint'(ay) * longint'(bz) - longint'(az) * longint'(by));
        cr[1] = magnitude(longint'(az) * longint'(bx) - longint'(ax) * longint'(bz));
        cr[2] = magnitude(longint'(ax) * longint'(by) - longint'(ay) * longint'(bx));
        dot   = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by)
              + longint'(az) * longint'(bz);
        dneg  = dot < 0;
        dmag  = magnitude(dot);
        mx    = dmag;
        for (int i = 0; i < 3; i++)
            if (cr[i] > mx)
                mx = cr[i];
        len = 0;
        while (mx != 0)
        begin
            len++;
            mx = mx >> 1;
        end
        for (int i = 0; i < 3; i++)
            cr[i] = (len > 31) ? cr[i] >> (len - 31) : cr[i] << (31 - len);
        dmag = (len > 31) ? dmag >> (len - 31) : dmag << (31 - len);
        leg  = int_sqrt(cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2]);
        x = longint'(dmag << va_pkg::LEG_SCALE);
        y = longint'(leg << va_pkg::LEG_SCALE);
        z = 0;
        for (int i = 0; i < va_pkg::CORDIC_ITERS; i++)
        begin
            xs = y >>> i;
            ys = x >>> i;
            if (y >= 0)
            begin
                x = x + xs;
                y = y - ys;
                z = z + longint'(arctan_q60[i]);
            end
            else
            begin
                x = x - xs;
                y = y + ys;
                z = z - longint'(arctan_q60[i]);
            end
        end
        half_pi = longint'(2 * arctan_q60[0]);
        pi_full = longint'(4 * arctan_q60[0]);
        if (z < 0)
            z = 0;
        if (z > half_pi)
            z = half_pi;
        if (dneg)
            z = pi_full - z;
        r.angle = va_pkg::ANGLE_W'((longint'(z) + (64'd1 << (va_pkg::ROUND_SHIFT - 1)))
                                   >> va_pkg::ROUND_SHIFT);
        r.degen = 1'b0;
        return r;
    endfunction

    // Sender: directed table first, then random pairs. Inputs change on the
    // falling edge; valid stays up from one item to the next unless a gap is taken.
    task automatic offer_pair(input vec_row_t row);
        bit calm;
        calm = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);
        while (!calm && $urandom_range(99) < 30)
        begin
            @(negedge clk);
            vec_valid <= 1'b0;
            a_x <= comp_t'($urandom);
        end
        @(negedge clk);
        vec_valid <= 1'b1;
        a_x <= row.ax;
        a_y <= row.ay;
        a_z <= row.az;
        b_x <= row.bx;
        b_y <= row.by;
        b_z <= row.bz;
        do
            @(posedge clk);
        while (!vec_ready);
        // The transfer happens at this edge; the expectation is filed here.
        if (row.typed)
            pending_angles.push_back('{angle: row.angle, degen: row.degen});
        else
            pending_angles.push_back(predict_angle(row.ax, row.ay, row.az,
                                                   row.bx, row.by, row.bz));
        n_sent++;
    endtask

    function automatic vec_row_t random_pair();
        vec_row_t r;
        int       k;
        int       sh;
        r.typed = 1'b0;
        r.angle = '0;
        r.degen = 1'b0;
        k = $urandom_range(99);
        r.ax = comp_t'($urandom);
        r.ay = comp_t'($urandom);
        r.az = comp_t'($urandom);
        r.bx = comp_t'($urandom);
        r.by = comp_t'($urandom);
        r.bz = comp_t'($urandom);
        if (k < 20)
        begin
            // Small components exercise the left-shifting normalisation.
            sh = $urandom_range(14, 4);
            r.ax = r.ax >>> sh;
            r.ay = r.ay >>> sh;
            r.az = r.az >>> sh;
            r.bx = r.bx >>> sh;
            r.by = r.by >>> sh;
            r.bz = r.bz >>> sh;
        end
        else if (k < 30)
        begin
            // b is a scaled copy of a, each component's sign picked at random, b.x nudged by up to one.
            sh = $urandom_range(3);
            r.ax = r.ax >>> 2;
            r.ay = r.ay >>> 2;
            r.az = r.az >>> 2;
            r.bx = ($urandom_range(1) ? r.ax : -r.ax) <<< sh;
            r.by = ($urandom_range(1) ? r.ay : -r.ay) <<< sh;
            r.bz = ($urandom_range(1) ? r.az : -r.az) <<< sh;
            r.bx = r.bx + comp_t'($urandom_range(2)) - 1;
        end
        else if (k < 38)
        begin
            // Orthogonal pair by construction.
            r.ax = r.ax >>> 1;
            r.ay = r.ay >>> 1;
            r.az = 0;
            r.bx = -r.ay;
            r.by = r.ax;
            r.bz = comp_t'($urandom);
        end
        else if (k < 43)
        begin
            if ($urandom_range(1))
            begin
                r.ax = 0;
                r.ay = 0;
                r.az = 0;
            end
            else
            begin
                r.bx = 0;
                r.by = 0;
                r.bz = 0;
            end
        end
        return r;
    endfunction

    initial
    begin
        vec_row_t vec_table[$];
        clk         = 1'b0;
        rst_n       = 1'b0;
        vec_valid   = 1'b0;
        a_x         = '0;
        a_y         = '0;
        a_z         = '0;
        b_x         = '0;
        b_y         = '0;
        b_z         = '0;
        n_sent      = 0;
        sender_done = 1'b0;
        arctan_q60[0] = 4 * arctan_inv(5) - arctan_inv(239);
        for (int i = 1; i < va_pkg::CORDIC_ITERS; i++)
            arctan_q60[i] = arctan_inv(64'd1 << i);

        //                   ax      ay      az      bx      by      bz  typed angle  deg
        vec_table = '{
            '{      0,      0,      0,      5,     -3,      2, 1, 15'd0,     1'b1},
            '{      7,      1,     -9,      0,      0,      0, 1, 15'd0,     1'b1},
            '{      0,      0,      0,      0,      0,      0, 1, 15'd0,     1'b1},
            '{      1,      0,      0,      1,      0,      0, 1, 15'd0,     1'b0},
            '{      1,      0,      0,     -1,      0,      0, 1, PI_Q,      1'b0},
            '{      1,      0,      0,      0,      1,      0, 1, HALF_PI_Q, 1'b0},
            '{      0,      0,  32767,  32767,      0,      0, 1, HALF_PI_Q, 1'b0},
            '{ -32768, -32768, -32768, -32768, -32768, -32768, 1, 15'd0,     1'b0},
            '{  32767,  32767,  32767, -32767, -32767, -32767, 1, PI_Q,      1'b0},
            '{  32767,  32767,  32767, -32768, -32768, -32768, 0, 15'd0,     1'b0},
            '{  32767, -32768,  32767, -32768,  32767, -32768, 0, 15'd0,     1'b0},
            '{ -32768,      0,      0,      0,      0,     -1, 1, HALF_PI_Q, 1'b0},
            '{      1,      1,      0,      1,      0,      0, 0, 15'd0,     1'b0},
            '{      1,      2,      3,     -3,     -2,     -1, 0, 15'd0,     1'b0},
            '{  32767,      1,      0,  32767,      0,      1, 0, 15'd0,     1'b0},
            '{     -1,     -1,     -1,  32767,  32767,  32767, 1, PI_Q,      1'b0},
            '{      3,      4,      0,      4,     -3,      0, 1, HALF_PI_Q, 1'b0},
            '{  12345, -23456,    789,  -1111,   2222,  31000, 0, 15'd0,     1'b0},
            '{  -5555,  -5555,   5555,   5555,   5555,  -5554, 0, 15'd0,     1'b0}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (vec_table[i])
            offer_pair(vec_table[i]);

        // Pause with valid low until the directed results have all come back.
        @(negedge clk);
        vec_valid <= 1'b0;
        wait (pending_angles.size() == 0);

        for (int i = 0; i < N_RANDOM; i++)
            offer_pair(random_pair());
        @(negedge clk);
        vec_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // Receiver back-pressure: random stalls, one long hold while the sender keeps
    // going so the chain fills and vec_ready drops, and a calm window.
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && n_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (n_sent >= CALM_FROM && n_sent < CALM_TO)
                res_ready <= 1'b1;
            else
                res_ready <= ($urandom_range(99) >= 30);
        end
    end

    // Result checker: every result transfer is matched with the oldest expectation.
    initial
    begin
        angle_res_t want;
        n_checked = 0;
        n_degen   = 0;
        n_errors  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
            begin
                if (pending_angles.size() == 0)
                begin
                    $error("unexpected result: angle_rad=%0d degenerate=%0b",
                           angle_rad, degenerate);
                    n_errors++;
                end
                else
                begin
                    want = pending_angles.pop_front();
                    if (angle_rad !== want.angle)
                    begin
                        $error("angle_rad: expected %0d, got %0d", want.angle, angle_rad);
                        n_errors++;
                    end
                    if (degenerate !== want.degen)
                    begin
                        $error("degenerate: expected %0b, got %0b", want.degen, degenerate);
                        n_errors++;
                    end
                    n_degen += want.degen;
                end
                n_checked++;
            end
        end
    end

    // End of run: drain, then keep watching for stray results before the summary.
    initial
    begin
        wait (sender_done);
        wait (pending_angles.size() == 0);
        repeat (250) @(posedge clk);
        $display("Sent %0d vector pairs, checked %0d angles, %0d of them degenerate.",
                 n_sent, n_checked, n_degen);
        $display("Covered zero vectors, parallel, antiparallel, orthogonal, extremes and stalls.");
        if (n_errors == 0 && pending_angles.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d results outstanding.", pending_angles.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* vector3_angle.f */
hdl/va_pkg.sv
hdl/va_front.sv
hdl/va_sqrt_cell.sv
hdl/va_cordic_cell.sv
hdl/va_back.sv
hdl/vector3_angle.sv
tb/testbench.sv
